// ----- design/bmph_pkg.sv -----
// Shared constants, types and the level-to-height table of the bar meter.
// Used by every module of the bar meter; depends on nothing else.
package bmph_pkg;

  localparam int unsigned BAND_W = 6;
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned VEL_W = 10;

  localparam int unsigned BANDS = 64;
  localparam int unsigned IDX_W = $clog2(BANDS);
  localparam int unsigned BAR_HEIGHT = 256;
  localparam int unsigned ROOF_START_VELOCITY = 32;

  localparam logic [PIX_W-1:0] ROOF_RESET = PIX_W'(BAR_HEIGHT - 5);
  localparam logic [VEL_W-1:0] VEL_RESET = VEL_W'(ROOF_START_VELOCITY);
  localparam logic [VEL_W-1:0] VEL_MAX = '1;
  localparam logic [VEL_W-1:0] VEL_KNEE = VEL_W'(32);
  localparam logic [VEL_W-1:0] VEL_RESTART = VEL_W'(1);

  // Division by 20 as a multiply by a scaled reciprocal; exact for 10-bit values.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [11:0] RECIP_20 = 12'd3277;
  localparam int unsigned DROP_W = 6;

  localparam logic [PIX_W-1:0] FALL_LIMIT_RESET = PIX_W'(5);

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FALL_LIMIT = '0;

  localparam int unsigned LOG_FRAC = 24;
  localparam int unsigned MANT_ONE = 30;

  typedef struct packed {
    logic [PIX_W-1:0] bar;
    logic [PIX_W-1:0] roof;
    logic [VEL_W-1:0] vel;
  } bmph_state_t;

  localparam bmph_state_t STATE_RESET = '{bar: '0, roof: ROOF_RESET, vel: VEL_RESET};

  typedef logic [PIX_W-1:0] level_map_t [256];

  // log2(n) with LOG_FRAC fraction bits, by repeated squaring of a Q30 mantissa.
  function automatic logic [63:0] fixed_log2(input int unsigned n);
    logic [63:0] m;
    logic [63:0] frac;
    int unsigned k;
    k = 0;
    frac = '0;
    if (n == 0) begin
      return '0;
    end
    for (int i = 0; i < 31; i++) begin
      if ((n >> (i + 1)) != 0) begin
        k = i + 1;
      end
    end
    m = (64'(n) << MANT_ONE) >> k;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> MANT_ONE;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_ONE)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(k) << LOG_FRAC) | frac;
  endfunction

  localparam logic [63:0] LogDen = fixed_log2(255);
  localparam logic [63:0] LogSpan = 64'(BAR_HEIGHT - 2);

  function automatic level_map_t build_level_map();
    level_map_t t;
    logic [63:0] v;
    for (int x = 0; x < 256; x++) begin
      v = (LogSpan * fixed_log2(x + 1)) / LogDen;
      if (v > 64'd255) begin
        v = 64'd255;
      end
      t[x] = v[PIX_W-1:0];
    end
    return t;
  endfunction

  localparam level_map_t LEVEL_MAP = build_level_map();

endpackage

// ----- design/bmph_cfg.sv -----
// APB-style register port holding the bar fall limit.
// Depends on bmph_pkg for the register index and reset value.
module bmph_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bmph_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bmph_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bmph_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [bmph_pkg::PIX_W-1:0]          fall_limit_o
);
  import bmph_pkg::*;

  logic [PIX_W-1:0] fall_limit_q;
  logic [PIX_W-1:0] fall_limit_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    fall_limit_d = fall_limit_q;
    if (wr_en && (reg_idx == REG_FALL_LIMIT)) begin
      fall_limit_d = pwdata[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_limit_q <= FALL_LIMIT_RESET;
    end else begin
      fall_limit_q <= fall_limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FALL_LIMIT) begin
      prdata = APB_DATA_W'(fall_limit_q);
    end
  end

  assign fall_limit_o = fall_limit_q;

endmodule

// ----- design/bmph_state_mem.sv -----
// Per-band state memory with registered read, valid bits and write bypass.
// Depends on bmph_pkg for the state record and its reset value.
module bmph_state_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [bmph_pkg::IDX_W-1:0]   rd_addr_i,
  output bmph_pkg::bmph_state_t        rd_data_o,
  input  logic                         wr_en_i,
  input  logic [bmph_pkg::IDX_W-1:0]   wr_addr_i,
  input  bmph_pkg::bmph_state_t        wr_data_i
);
  import bmph_pkg::*;

  bmph_state_t mem [BANDS];
  bmph_state_t mem_rd_q;
  bmph_state_t byp_data_q;
  logic [BANDS-1:0] valid_q;
  logic hit_q;
  logic byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
        byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (hit_q) begin
      rd_data_o = mem_rd_q;
    end else begin
      rd_data_o = STATE_RESET;
    end
  end

endmodule

// ----- design/bmph_update.sv -----
// Bar and roof update for one band: level mapping, bar fall limit, roof fall.
// Depends on bmph_pkg for the level table, constants and the state record.
module bmph_update (
  input  logic [bmph_pkg::LEVEL_W-1:0] level_i,
  input  logic [bmph_pkg::PIX_W-1:0]   fall_limit_i,
  input  bmph_pkg::bmph_state_t        cur_i,
  output bmph_pkg::bmph_state_t        nxt_o
);
  import bmph_pkg::*;

  logic [PIX_W-1:0] lvl;
  logic [PIX_W-1:0] mapped;
  logic [PIX_W-1:0] floor_lvl;
  logic [PIX_W-1:0] bar_new;
  logic [PIX_W-1:0] roof_mid;
  logic [VEL_W-1:0] vel_mid;
  logic [VEL_W-1:0] excess;
  logic [VEL_W+11:0] prod;
  logic [DROP_W-1:0] drop;
  logic [PIX_W:0] roof_diff;

  assign lvl = (|level_i[LEVEL_W-1:PIX_W]) ? '1 : level_i[PIX_W-1:0];
  assign mapped = LEVEL_MAP[lvl];
  assign floor_lvl = (cur_i.bar > fall_limit_i) ? (cur_i.bar - fall_limit_i) : '0;
  assign bar_new = (mapped > floor_lvl) ? mapped : floor_lvl;

  always_comb begin
    if (bar_new > cur_i.roof) begin
      roof_mid = bar_new;
      vel_mid = VEL_RESTART;
    end else begin
      roof_mid = cur_i.roof;
      vel_mid = cur_i.vel;
    end
  end

  assign excess = (vel_mid > VEL_KNEE) ? (vel_mid - VEL_KNEE) : '0;
  assign prod = (VEL_W + 12)'(excess) * (VEL_W + 12)'(RECIP_20);
  assign drop = prod[RECIP_SHIFT +: DROP_W];
  assign roof_diff = {1'b0, roof_mid} - (PIX_W + 1)'(drop);

  always_comb begin
    nxt_o.bar = bar_new;
    nxt_o.roof = roof_mid;
    nxt_o.vel = vel_mid;
    if (vel_mid != '0) begin
      if (roof_diff[PIX_W]) begin
        nxt_o.roof = '0;
        nxt_o.vel = '0;
      end else begin
        nxt_o.roof = roof_diff[PIX_W-1:0];
        if (vel_mid < VEL_MAX) begin
          nxt_o.vel = vel_mid + VEL_W'(1);
        end
      end
    end
  end

endmodule

// ----- design/bar_meter_peak_hold.sv -----
// Top level of the per-band bar meter with falling peak roof.
// Instantiates bmph_cfg, bmph_state_mem and bmph_update; uses bmph_pkg.
//
//   Port group      Direction  Handshake                Payload
//   request in      input      in_valid_i / in_stall_o  band_i, level_i, frame_update_i
//   result out      output     out_valid_o / out_stall_i bar_level_o, roof_level_o
//   config          APB        psel, penable, pready    paddr, pwdata, prdata
//
// One request per cycle is sustained while the result is not stalled; the state
// memory read is registered with the request, the update runs in the following
// cycle, and its result is registered into the output stage before it is offered.
// Back-to-back requests to the same band are served by a write bypass.
// Reset clears the valid bits, so every band reads its reset state at once.
// A stalled result holds; the input stalls when both stages are full and the
// result is stalled.
module bar_meter_peak_hold (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bmph_pkg::BAND_W-1:0]         band_i,
  input  logic [bmph_pkg::LEVEL_W-1:0]        level_i,
  input  logic                                frame_update_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bmph_pkg::PIX_W-1:0]          bar_level_o,
  output logic [bmph_pkg::PIX_W-1:0]          roof_level_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bmph_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bmph_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bmph_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import bmph_pkg::*;

  logic [PIX_W-1:0] fall_limit;
  logic accept;
  logic out_free;
  logic s1_adv;
  logic in_range;
  logic wr_en;

  logic s1_valid_q;
  logic s1_valid_d;
  logic [BAND_W-1:0] s1_band_q;
  logic [LEVEL_W-1:0] s1_level_q;
  logic s1_update_q;
  logic s1_range_q;

  logic out_valid_q;
  logic out_valid_d;
  logic [PIX_W-1:0] bar_q;
  logic [PIX_W-1:0] roof_q;

  bmph_state_t cur_state;
  bmph_state_t nxt_state;
  bmph_state_t res_state;

  bmph_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fall_limit_o (fall_limit)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept = in_valid_i && !in_stall_o;
  assign in_range = (BAND_W + 1)'(band_i) < (BAND_W + 1)'(BANDS);
  assign wr_en = s1_adv && s1_update_q && s1_range_q;

  bmph_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (band_i[IDX_W-1:0]),
    .rd_data_o (cur_state),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_band_q[IDX_W-1:0]),
    .wr_data_i (nxt_state)
  );

  bmph_update u_update (
    .level_i      (s1_level_q),
    .fall_limit_i (fall_limit),
    .cur_i        (cur_state),
    .nxt_o        (nxt_state)
  );

  always_comb begin
    if (!s1_range_q) begin
      res_state = '0;
    end else if (s1_update_q) begin
      res_state = nxt_state;
    end else begin
      res_state = cur_state;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_band_q <= band_i;
      s1_level_q <= level_i;
      s1_update_q <= frame_update_i;
      s1_range_q <= in_range;
    end
    if (s1_adv) begin
      bar_q <= res_state.bar;
      roof_q <= res_state.roof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bar_level_o = bar_q;
  assign roof_level_o = roof_q;

endmodule

// ----- dv/tb_bar_meter_peak_hold.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bar_meter_peak_hold: a directed table of band requests, then
// random request bursts, checked against the table or an in-bench model of bar and roof.
// Depends on bmph_pkg and the bar_meter_peak_hold RTL.
module tb_bar_meter_peak_hold;
  import bmph_pkg::*;

  localparam int unsigned NUM_DIR = 24;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned PHASE_REQS = 260;
  localparam int unsigned IDLE_PCT = 7;
  localparam int unsigned MAX_REPORTS = 200;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(1);

  typedef struct packed {
    logic [PIX_W-1:0] bar;
    logic [PIX_W-1:0] roof;
  } heights_t;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
    logic               upd;
    logic               known;
    heights_t           heights;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [BAND_W-1:0]     band_i;
  logic [LEVEL_W-1:0]    level_i;
  logic                  frame_update_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PIX_W-1:0]      bar_level_o;
  logic [PIX_W-1:0]      roof_level_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [PIX_W-1:0] height_lut [256];
  logic [PIX_W-1:0] bar_mem [BANDS];
  logic [PIX_W-1:0] roof_mem [BANDS];
  logic [VEL_W-1:0] vel_mem [BANDS];
  logic [PIX_W-1:0] fall_lim;
  heights_t         pending_heights_q [$];
  int unsigned      err_cnt;
  logic             gaps_on;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{6'd0,  12'd0,    1'b0, 1'b1, '{8'd0,   8'd251}},
    '{6'd63, 12'd0,    1'b0, 1'b1, '{8'd0,   8'd251}},
    '{6'd1,  12'd4095, 1'b1, 1'b1, '{8'd254, 8'd254}},
    '{6'd1,  12'd0,    1'b1, 1'b1, '{8'd249, 8'd254}},
    '{6'd1,  12'd0,    1'b0, 1'b1, '{8'd249, 8'd254}},
    '{6'd1,  12'd0,    1'b1, 1'b1, '{8'd244, 8'd254}},
    '{6'd2,  12'd0,    1'b1, 1'b1, '{8'd0,   8'd251}},
    '{6'd3,  12'd255,  1'b1, 1'b1, '{8'd254, 8'd254}},
    '{6'd4,  12'd256,  1'b1, 1'b1, '{8'd254, 8'd254}},
    '{6'd5,  12'd1,    1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd5,  12'd2,    1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd6,  12'd128,  1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd6,  12'd127,  1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd63, 12'd4095, 1'b1, 1'b1, '{8'd254, 8'd254}},
    '{6'd63, 12'd2048, 1'b0, 1'b1, '{8'd254, 8'd254}},
    '{6'd2,  12'd4094, 1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd7,  12'hAAA,  1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd8,  12'h555,  1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd42, 12'h800,  1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd21, 12'h0FF,  1'b1, 1'b1, '{8'd254, 8'd254}},
    '{6'd9,  12'd3000, 1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd9,  12'd0,    1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd9,  12'd0,    1'b1, 1'b0, '{8'd0,   8'd0}},
    '{6'd9,  12'd0,    1'b1, 1'b0, '{8'd0,   8'd0}}
  };

  bar_meter_peak_hold u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .band_i         (band_i),
    .level_i        (level_i),
    .frame_update_i (frame_update_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bar_level_o    (bar_level_o),
    .roof_level_o   (roof_level_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] log2_q24(input int unsigned n);
    logic [63:0] mant;
    logic [63:0] frac;
    int unsigned whole;
    whole = $clog2(n + 1) - 1;
    mant = (64'(n) << 30) >> whole;
    frac = '0;
    repeat (24) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(whole) << 24) | frac;
  endfunction

  function automatic void fill_height_lut();
    logic [63:0] full;
    logic [63:0] h;
    full = log2_q24(255);
    for (int x = 0; x < 256; x++) begin
      h = (64'(BAR_HEIGHT - 2) * log2_q24(x + 1)) / full;
      height_lut[x] = (h > 64'd255) ? 8'd255 : h[PIX_W-1:0];
    end
  endfunction

  function automatic void reset_meter();
    fall_lim = FALL_LIMIT_RESET;
    for (int i = 0; i < BANDS; i++) begin
      bar_mem[i] = '0;
      roof_mem[i] = PIX_W'(BAR_HEIGHT - 5);
      vel_mem[i] = VEL_W'(ROOF_START_VELOCITY);
    end
  endfunction

  // Applies one request to the band's bar, roof and roof velocity, and returns the
  // heights that the band shows afterward.
  function automatic heights_t advance_band(input logic [BAND_W-1:0] b,
                                            input logic [LEVEL_W-1:0] lvl,
                                            input logic upd);
    heights_t r;
    int y;
    int bar;
    int roof;
    int vel;
    if (upd) begin
      y = int'(height_lut[(lvl > LEVEL_W'(255)) ? 8'd255 : lvl[7:0]]);
      bar = int'(bar_mem[b]);
      roof = int'(roof_mem[b]);
      vel = int'(vel_mem[b]);
      if (y - bar < -int'(fall_lim)) begin
        y = bar - int'(fall_lim);
      end
      if (y < 0) begin
        y = 0;
      end
      if (y > roof) begin
        roof = y;
        vel = 1;
      end
      bar = y;
      if (vel != 0) begin
        if (vel > 32) begin
          roof = roof - (vel - 32) / 20;
        end
        if (roof < 0) begin
          roof = 0;
          vel = 0;
        end else if (vel < 1023) begin
          vel = vel + 1;
        end
      end
      if (roof > 255) begin
        roof = 255;
      end
      bar_mem[b] = PIX_W'(bar);
      roof_mem[b] = PIX_W'(roof);
      vel_mem[b] = VEL_W'(vel);
    end
    r.bar = bar_mem[b];
    r.roof = roof_mem[b];
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) begin
      return '0;
    end else if (r < 30) begin
      return LEVEL_W'($urandom_range(8, 1));
    end else if (r < 65) begin
      return LEVEL_W'($urandom_range(255));
    end else if (r < 85) begin
      return LEVEL_W'($urandom_range(4095, 256));
    end else if (r < 92) begin
      return LEVEL_W'(4095);
    end
    return LEVEL_W'($urandom);
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_FALL_LIMIT) begin
      fall_lim = data[PIX_W-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic check_fall_limit();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_FALL_LIMIT, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[PIX_W-1:0] !== fall_lim) begin
      note_mismatch("fall_limit readback", 32'(fall_lim), 32'(prdata[PIX_W-1:0]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_request(input logic [BAND_W-1:0] b, input logic [LEVEL_W-1:0] lvl,
                              input logic upd, input logic known, input heights_t typed);
    heights_t pred;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    band_i <= b;
    level_i <= lvl;
    frame_update_i <= upd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = advance_band(b, lvl, upd);
    pending_heights_q.push_back(known ? typed : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_heights_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly short bursts of random requests; some bursts hit one band from full scale
  // with near-zero levels so that its roof falls, and in long bursts can fall to zero and freeze.
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    logic decay;
    logic [BAND_W-1:0] b;
    logic [BAND_W-1:0] req_band;
    logic [LEVEL_W-1:0] lvl;
    logic upd;
    sent = 0;
    while (sent < n) begin
      b = BAND_W'($urandom);
      decay = ($urandom_range(99) < 12);
      len = decay ? $urandom_range(200, 60) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        if (decay) begin
          req_band = b;
          if (i == 0) begin
            lvl = LEVEL_W'(4095);
          end else if ($urandom_range(99) < 90) begin
            lvl = '0;
          end else begin
            lvl = LEVEL_W'($urandom_range(3));
          end
          upd = (i == 0) || ($urandom_range(99) < 95);
        end else begin
          req_band = ($urandom_range(1) == 0) ? b : BAND_W'($urandom);
          lvl = rand_level();
          upd = ($urandom_range(99) < 85);
        end
        send_request(req_band, lvl, upd, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    heights_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_heights_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no request pending, bar_level %0d, roof_level %0d",
                 $time, bar_level_o, roof_level_o);
      end else begin
        want = pending_heights_q.pop_front();
        if (bar_level_o !== want.bar) begin
          note_mismatch("bar_level", 32'(want.bar), 32'(bar_level_o));
        end
        if (roof_level_o !== want.roof) begin
          note_mismatch("roof_level", 32'(want.roof), 32'(roof_level_o));
        end
      end
    end
    out_stall_i <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  initial begin
    logic [PIX_W-1:0] limits [NUM_PHASES];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    band_i = '0;
    level_i = '0;
    frame_update_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    err_cnt = 0;
    fill_height_lut();
    reset_meter();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_fall_limit();
    for (int i = 0; i < NUM_DIR; i++) begin
      send_request(dir_rows[i].band, dir_rows[i].level, dir_rows[i].upd,
                   dir_rows[i].known, dir_rows[i].heights);
    end
    drain();
    // A zero limit holds every bar; the phase with p == 2 runs without any idling.
    limits = '{8'd0, 8'd255, 8'd1, PIX_W'($urandom_range(254, 2)), PIX_W'($urandom)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      gaps_on <= (p != 2);
      apb_write(REG_FALL_LIMIT, {24'($urandom), limits[p]});
      apb_write(REG_SPARE, $urandom);
      check_fall_limit();
      run_random(PHASE_REQS);
      drain();
    end
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- bar_meter_peak_hold.f -----
design/bmph_pkg.sv
design/bmph_cfg.sv
design/bmph_state_mem.sv
design/bmph_update.sv
design/bar_meter_peak_hold.sv
dv/tb_bar_meter_peak_hold.sv
